// ----- sv/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants and codes for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int unsigned HEAP_BYTES_DEF   = 4096;
  localparam int unsigned HEADER_BYTES_DEF = 16;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned ADDR_W   = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_DEFRAG = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_ALLOC_ERR = 2'd1,
    ST_BAD_FREE  = 2'd2,
    ST_RSVD      = 2'd3
  } status_t;

endpackage

// ----- sv/ffha_mem.sv -----
// ----------------------------------------------------------------------------
// ffha_mem
// Block table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffha_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 15
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- sv/first_fit_heap_allocator.sv -----
// A request walks the block table, visiting blocks and probing or merging the blocks that follow;
// a no-op or a request rejected on arrival is answered without reading the table.
// Throughput: one request at a time; the walk through the block table memory sets the rate.
// Reset: synchronous, active low. After reset a clearing pass writes all HEAP_BYTES
// block table entries; no request is accepted until it ends.
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap manager kept as a linked block table in one memory.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [ffha_pkg::ADDR_W-1:0]   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ffha_pkg::ACTION_W-1:0] in_action,
  input  logic [ffha_pkg::ADDR_W-1:0]   in_request_size,
  input  logic [ffha_pkg::ADDR_W-1:0]   in_free_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ffha_pkg::ADDR_W-1:0]   out_result_address,
  output logic [ffha_pkg::STATUS_W-1:0] out_status,
  output logic [ffha_pkg::COUNT_W-1:0]  out_merged_count,
  output logic [ffha_pkg::COUNT_W-1:0]  out_block_count
);
  import ffha_pkg::*;

  localparam int unsigned AW = $clog2(HEAP_BYTES);
  localparam int unsigned PW = AW + 1;
  localparam int unsigned EW = PW + 2;
  localparam int unsigned CW = ADDR_W + 2;
  localparam logic [PW-1:0] HEAP_P = PW'(HEAP_BYTES);

  // Table entry: {start, used, next block offset}.
  typedef struct packed {
    logic          start;
    logic          used;
    logic [PW-1:0] nxt;
  } entry_t;

  typedef enum logic [8:0] {
    S_CLR  = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_RDC  = 9'b000000100,
    S_CUR  = 9'b000001000,
    S_EVAL = 9'b000010000,
    S_RDN  = 9'b000100000,
    S_NXT  = 9'b001000000,
    S_WSPL = 9'b010000000,
    S_WCUR = 9'b100000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [PW-1:0]       clr_r, clr_nxt;
  logic [ADDR_W-1:0]   base_r;
  action_t             op_r, op_nxt;
  logic [ADDR_W-1:0]   req_r, req_nxt;
  logic [PW-1:0]       o_r, o_nxt;
  logic                cu_r, cu_nxt;
  logic [PW-1:0]       cn_r, cn_nxt;
  logic                dirty_r, dirty_nxt;
  logic                tried_r, tried_nxt;
  logic [COUNT_W-1:0]  blocks_r, blocks_nxt;
  logic [COUNT_W-1:0]  merged_r, merged_nxt;
  logic                done_r, done_nxt;
  logic [ADDR_W-1:0]   raddr_r, raddr_nxt;
  status_t             rstat_r, rstat_nxt;

  logic                out_valid_r;
  logic [ADDR_W-1:0]   out_addr_r;
  status_t             out_stat_r;
  logic [COUNT_W-1:0]  out_merged_r, out_blocks_r;

  logic                we;
  logic [AW-1:0]       wa, ra;
  entry_t              wd, rd;
  logic [EW-1:0]       rd_raw;

  logic [PW-1:0]       span;
  logic [CW-1:0]       size_c, req_c;
  logic [ADDR_W-1:0]   free_off;
  logic                accept;

  ffha_mem #(.DEPTH(HEAP_BYTES), .WIDTH(EW)) u_mem (
    .clk     (clk),
    .wr_en   (we),
    .wr_addr (wa),
    .wr_data (wd),
    .rd_addr (ra),
    .rd_data (rd_raw)
  );
  assign rd = entry_t'(rd_raw);

  assign span     = cn_r - o_r;
  assign size_c   = (span > PW'(HEADER_BYTES)) ? CW'(span - PW'(HEADER_BYTES)) : '0;
  assign req_c    = CW'(req_r);
  assign free_off = in_free_address - base_r - ADDR_W'(HEADER_BYTES);
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE) || done_r;

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    op_nxt     = op_r;
    req_nxt    = req_r;
    o_nxt      = o_r;
    cu_nxt     = cu_r;
    cn_nxt     = cn_r;
    dirty_nxt  = dirty_r;
    tried_nxt  = tried_r;
    blocks_nxt = blocks_r;
    merged_nxt = merged_r;
    done_nxt   = done_r;
    raddr_nxt  = raddr_r;
    rstat_nxt  = rstat_r;
    we         = 1'b0;
    wa         = o_r[AW-1:0];
    wd         = '{start: 1'b1, used: cu_r, nxt: cn_r};
    ra         = o_r[AW-1:0];

    if (done_r && (!out_valid_r || !out_stall)) begin
      done_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        we = 1'b1;
        wa = clr_r[AW-1:0];
        wd = '{start: (clr_r == '0), used: 1'b0, nxt: HEAP_P};
        clr_nxt = clr_r + 1'b1;
        if (clr_r == HEAP_P - 1'b1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_nxt     = action_t'(in_action);
          req_nxt    = in_request_size;
          merged_nxt = '0;
          raddr_nxt  = '0;
          rstat_nxt  = ST_OK;
          o_nxt      = '0;
          dirty_nxt  = 1'b0;
          unique case (action_t'(in_action))
            ACT_ALLOC: begin
              if (in_request_size == '0) begin
                rstat_nxt = ST_ALLOC_ERR;
                done_nxt  = 1'b1;
              end else begin
                state_nxt = S_RDC;
              end
            end
            ACT_FREE: begin
              if (in_free_address == '0 || free_off >= ADDR_W'(HEAP_BYTES)) begin
                rstat_nxt = ST_BAD_FREE;
                done_nxt  = 1'b1;
              end else begin
                o_nxt     = PW'(free_off);
                state_nxt = S_RDC;
              end
            end
            ACT_DEFRAG: state_nxt = S_RDC;
            default:    done_nxt  = 1'b1;
          endcase
        end
      end
      S_RDC: begin
        state_nxt = S_CUR;
      end
      S_CUR: begin
        cu_nxt    = rd.used;
        cn_nxt    = rd.nxt;
        tried_nxt = 1'b0;
        dirty_nxt = 1'b0;
        state_nxt = S_EVAL;
        if (op_r == ACT_FREE) begin
          if (!rd.start) begin
            rstat_nxt = ST_BAD_FREE;
            done_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cu_nxt    = 1'b0;
            dirty_nxt = 1'b1;
          end
        end
      end
      S_EVAL: begin
        if (op_r == ACT_FREE) begin
          if (cn_r < HEAP_P && !tried_r) begin
            state_nxt = S_RDN;
          end else begin
            we        = 1'b1;
            done_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (!cu_r && cn_r < HEAP_P && !tried_r &&
                     (op_r == ACT_DEFRAG || req_c > size_c)) begin
          state_nxt = S_RDN;
        end else if (op_r == ACT_ALLOC && !cu_r && req_c <= size_c) begin
          cu_nxt    = 1'b1;
          raddr_nxt = base_r + ADDR_W'(o_r) + ADDR_W'(HEADER_BYTES);
          if (req_c + CW'(HEADER_BYTES) < size_c) begin
            state_nxt = S_WSPL;
          end else begin
            state_nxt = S_WCUR;
          end
        end else begin
          // Leave this block, writing back any merges done on it.
          we    = dirty_r;
          o_nxt = cn_r;
          if (cn_r >= HEAP_P) begin
            if (op_r == ACT_ALLOC) begin
              rstat_nxt = ST_ALLOC_ERR;
            end
            done_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_RDC;
          end
        end
      end
      S_RDN: begin
        ra        = cn_r[AW-1:0];
        state_nxt = S_NXT;
      end
      S_NXT: begin
        if (!rd.used) begin
          we         = 1'b1;
          wa         = cn_r[AW-1:0];
          wd         = '{start: 1'b0, used: 1'b0, nxt: HEAP_P};
          cn_nxt     = rd.nxt;
          dirty_nxt  = 1'b1;
          blocks_nxt = blocks_r - 1'b1;
          if (op_r == ACT_DEFRAG) begin
            merged_nxt = merged_r + 1'b1;
          end
        end else begin
          tried_nxt = 1'b1;
        end
        if (op_r == ACT_FREE) begin
          tried_nxt = 1'b1;
        end
        state_nxt = S_EVAL;
      end
      S_WSPL: begin
        we         = 1'b1;
        wa         = AW'(o_r + PW'(HEADER_BYTES) + PW'(req_r));
        wd         = '{start: 1'b1, used: 1'b0, nxt: cn_r};
        cn_nxt     = PW'(o_r + PW'(HEADER_BYTES) + PW'(req_r));
        blocks_nxt = blocks_r + 1'b1;
        state_nxt  = S_WCUR;
      end
      S_WCUR: begin
        we        = 1'b1;
        done_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      base_r      <= '0;
      blocks_r    <= COUNT_W'(1);
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      blocks_r <= blocks_nxt;
      done_r   <= done_nxt;
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
      if (done_r && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    req_r    <= req_nxt;
    o_r      <= o_nxt;
    cu_r     <= cu_nxt;
    cn_r     <= cn_nxt;
    dirty_r  <= dirty_nxt;
    tried_r  <= tried_nxt;
    merged_r <= merged_nxt;
    raddr_r  <= raddr_nxt;
    rstat_r  <= rstat_nxt;
    if (done_r && (!out_valid_r || !out_stall)) begin
      out_addr_r   <= (rstat_r == ST_OK) ? raddr_r : '0;
      out_stat_r   <= rstat_r;
      out_merged_r <= merged_r;
      out_blocks_r <= blocks_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_address = out_addr_r;
  assign out_status         = out_stat_r;
  assign out_merged_count   = out_merged_r;
  assign out_block_count    = out_blocks_r;

endmodule

// ----- verif/tb_first_fit_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator
// Self-checking bench for the first-fit heap allocator. A directed table
// covers the corner requests, then random allocate/free/defragment traffic
// runs under several heap base settings. Each response is checked against
// its directed row or a behavioral block-map model kept inside the bench.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import ffha_pkg::*;

  localparam int unsigned HEAP = HEAP_BYTES_DEF;
  localparam int unsigned HDR  = HEADER_BYTES_DEF;
  localparam int unsigned STALL_LIMIT = 400000;
  localparam int unsigned RANDOM_ITEMS = 1800;

  typedef struct {
    logic [ADDR_W-1:0]  address;
    status_t            status;
    logic [COUNT_W-1:0] merged;
    logic [COUNT_W-1:0] blocks;
  } response_t;

  typedef struct {
    action_t           action;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] faddr;
    bit                base_rel;  // faddr is an offset from the heap base
    bit                typed;     // expected response given in the row
    logic [ADDR_W-1:0] exp_addr;  // offset from the heap base when nonzero
    status_t           exp_status;
    int unsigned       exp_blocks;
  } row_t;

  logic clk, rst_n;
  logic cfg_wr_en;
  logic [ADDR_W-1:0] cfg_wr_data;
  logic in_valid, in_stall;
  logic [ACTION_W-1:0] in_action;
  logic [ADDR_W-1:0] in_request_size, in_free_address;
  logic out_valid, out_stall;
  logic [ADDR_W-1:0] out_result_address;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0] out_merged_count, out_block_count;

  first_fit_heap_allocator uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_action(in_action), .in_request_size(in_request_size),
    .in_free_address(in_free_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_address(out_result_address), .out_status(out_status),
    .out_merged_count(out_merged_count), .out_block_count(out_block_count)
  );

  // Block-map model of the heap.
  bit                start_map[HEAP];
  bit                used_map[HEAP];
  int unsigned       num_blocks;
  logic [ADDR_W-1:0] heap_base;

  response_t         pending_responses[$];
  logic [ADDR_W-1:0] live_addrs[$];
  logic [ADDR_W-1:0] released_addrs[$];
  int unsigned       error_count;
  bit                quiet_phase;  // no idling on either side

  function automatic int unsigned next_start(int unsigned o);
    for (int unsigned p = o + 1; p < HEAP; p++)
      if (start_map[p]) return p;
    return HEAP;
  endfunction

  function automatic longint unsigned payload(int unsigned o);
    longint unsigned span;
    span = next_start(o) - o;
    return (span <= HDR) ? 0 : span - HDR;
  endfunction

  function automatic bit next_free(int unsigned o);
    int unsigned n;
    n = next_start(o);
    return n < HEAP && !used_map[n];
  endfunction

  function automatic void absorb(int unsigned o);
    int unsigned n;
    n = next_start(o);
    if (n < HEAP) begin
      start_map[n] = 0;
      used_map[n] = 0;
      num_blocks--;
    end
  endfunction

  function automatic bit heap_allocate(longint unsigned req, output logic [ADDR_W-1:0] addr);
    int unsigned o;
    o = 0;
    addr = '0;
    if (req == 0) return 0;
    while (o < HEAP) begin
      if (!used_map[o]) begin
        while (req > payload(o) && next_free(o)) absorb(o);
        if (req <= payload(o)) begin
          if (req + HDR < payload(o)) begin
            start_map[o + HDR + req] = 1;
            used_map[o + HDR + req] = 0;
            num_blocks++;
          end
          used_map[o] = 1;
          addr = heap_base + o + HDR;
          return 1;
        end
      end
      o = next_start(o);
    end
    return 0;
  endfunction

  function automatic bit heap_release(logic [ADDR_W-1:0] address);
    logic [ADDR_W-1:0] off;
    if (address == 0) return 0;
    off = address - heap_base - HDR;
    if (off >= HEAP || !start_map[off]) return 0;
    used_map[off] = 0;
    if (next_free(off)) absorb(off);
    return 1;
  endfunction

  function automatic int unsigned heap_defragment();
    int unsigned merged, o;
    merged = 0;
    o = 0;
    while (o < HEAP) begin
      if (!used_map[o] && next_free(o)) begin
        absorb(o);
        merged++;
      end else begin
        o = next_start(o);
      end
    end
    return merged;
  endfunction

  function automatic response_t heap_command(action_t act, logic [ADDR_W-1:0] size,
                                             logic [ADDR_W-1:0] faddr);
    response_t r;
    r.address = '0;
    r.status = ST_OK;
    r.merged = '0;
    case (act)
      ACT_ALLOC: begin
        if (!heap_allocate(size, r.address)) begin
          r.address = '0;
          r.status = ST_ALLOC_ERR;
        end
      end
      ACT_FREE: begin
        if (!heap_release(faddr)) r.status = ST_BAD_FREE;
      end
      ACT_DEFRAG: begin
        r.merged = COUNT_W'(heap_defragment());
      end
      default: ;
    endcase
    r.blocks = COUNT_W'(num_blocks);
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Sends one request and records its expected response at acceptance.
  task automatic send_request(action_t act, logic [ADDR_W-1:0] size,
                              logic [ADDR_W-1:0] faddr, bit use_typed,
                              response_t typed_resp);
    response_t r;
    while (!quiet_phase && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_request_size <= size;
    in_free_address <= faddr;
    do @(posedge clk); while (in_stall);
    r = heap_command(act, size, faddr);
    if (act == ACT_ALLOC && r.status == ST_OK) live_addrs.push_back(r.address);
    pending_responses.push_back(use_typed ? typed_resp : r);
    @(negedge clk);
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_heap_base(logic [ADDR_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    heap_base = value;
    live_addrs.delete();
    released_addrs.delete();
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_item();
    int unsigned pick, idx;
    logic [ADDR_W-1:0] size, faddr;
    response_t none;
    none.address = '0;
    none.status = ST_OK;
    none.merged = '0;
    none.blocks = '0;
    pick = $urandom_range(99);
    size = $urandom_range(1, 120);
    faddr = $urandom;
    if (pick < 45) begin
      case ($urandom_range(9))
        0: size = $urandom_range(1, 4096);
        1: size = $urandom;
        2: size = 0;
        default: ;
      endcase
      send_request(ACT_ALLOC, size, faddr, 0, none);
    end else if (pick < 82 && live_addrs.size() != 0) begin
      idx = $urandom_range(live_addrs.size() - 1);
      faddr = live_addrs[idx];
      live_addrs.delete(idx);
      released_addrs.push_back(faddr);
      if (released_addrs.size() > 16) void'(released_addrs.pop_front());
      send_request(ACT_FREE, size, faddr, 0, none);
    end else if (pick < 87 && released_addrs.size() != 0) begin
      // Freeing an address again, which may or may not still be a block start.
      faddr = released_addrs[$urandom_range(released_addrs.size() - 1)];
      send_request(ACT_FREE, size, faddr, 0, none);
    end else if (pick < 90) begin
      if ($urandom_range(1)) faddr = heap_base + HDR + $urandom_range(HEAP);
      send_request(ACT_FREE, size, faddr, 0, none);
    end else if (pick < 97) begin
      send_request(ACT_DEFRAG, size, faddr, 0, none);
    end else begin
      send_request(ACT_NOP, size, faddr, 0, none);
    end
  endtask

  row_t directed_rows[$] = '{
    '{ACT_NOP,    32'd5,          32'd7,          0, 1, 0,   ST_OK,        1},
    '{ACT_ALLOC,  32'd0,          32'd0,          0, 1, 0,   ST_ALLOC_ERR, 1},
    '{ACT_FREE,   32'd0,          32'd0,          0, 1, 0,   ST_BAD_FREE,  1},
    '{ACT_ALLOC,  32'hFFFF_FFFF,  32'd0,          0, 1, 0,   ST_ALLOC_ERR, 1},
    '{ACT_ALLOC,  32'd4081,       32'd0,          0, 1, 0,   ST_ALLOC_ERR, 1},
    '{ACT_ALLOC,  32'd4080,       32'd0,          0, 1, 16,  ST_OK,        1},
    '{ACT_ALLOC,  32'd1,          32'd0,          0, 1, 0,   ST_ALLOC_ERR, 1},
    '{ACT_FREE,   32'd0,          32'd16,         1, 1, 0,   ST_OK,        1},
    '{ACT_FREE,   32'd0,          32'd17,         1, 1, 0,   ST_BAD_FREE,  1},
    '{ACT_FREE,   32'd0,          32'hFFFF_FFFF,  0, 1, 0,   ST_BAD_FREE,  1},
    '{ACT_DEFRAG, 32'd0,          32'd0,          0, 1, 0,   ST_OK,        1},
    '{ACT_ALLOC,  32'd100,        32'd0,          0, 0, 0,   ST_OK,        0},
    '{ACT_ALLOC,  32'd1,          32'd0,          0, 0, 0,   ST_OK,        0},
    '{ACT_ALLOC,  32'd50,         32'd0,          0, 0, 0,   ST_OK,        0},
    '{ACT_ALLOC,  32'd3000,       32'd0,          0, 0, 0,   ST_OK,        0},
    '{ACT_FREE,   32'd0,          32'd132,        1, 0, 0,   ST_OK,        0},
    '{ACT_FREE,   32'd0,          32'd16,         1, 0, 0,   ST_OK,        0},
    '{ACT_FREE,   32'd0,          32'd16,         1, 0, 0,   ST_OK,        0},
    '{ACT_FREE,   32'd0,          32'd149,        1, 0, 0,   ST_OK,        0},
    '{ACT_DEFRAG, 32'd0,          32'd0,          0, 0, 0,   ST_OK,        0},
    '{ACT_ALLOC,  32'd200,        32'd0,          0, 0, 0,   ST_OK,        0},
    '{ACT_ALLOC,  32'h8000_0000,  32'd0,          0, 0, 0,   ST_ALLOC_ERR, 0},
    '{ACT_NOP,    32'hFFFF_FFFF,  32'hFFFF_FFFF,  0, 0, 0,   ST_OK,        0}
  };

  logic [ADDR_W-1:0] base_settings[4] = '{32'h0000_0000, 32'hFFFF_FFF0,
                                          32'hFFFF_FFFF, 32'h1234_5000};

  initial begin
    response_t typed_resp;
    logic [ADDR_W-1:0] faddr;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_action = ACT_NOP;
    in_request_size = '0;
    in_free_address = '0;
    error_count = 0;
    quiet_phase = 0;
    foreach (start_map[i]) begin
      start_map[i] = 0;
      used_map[i] = 0;
    end
    start_map[0] = 1;
    num_blocks = 1;
    heap_base = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 4; phase++) begin
      write_heap_base(phase == 3 ? $urandom : base_settings[phase]);
      if (phase == 0) begin
        foreach (directed_rows[i]) begin
          faddr = directed_rows[i].base_rel ? heap_base + directed_rows[i].faddr
                                            : directed_rows[i].faddr;
          typed_resp.address = (directed_rows[i].exp_addr != 0)
                               ? heap_base + directed_rows[i].exp_addr : '0;
          typed_resp.status = directed_rows[i].exp_status;
          typed_resp.merged = '0;
          typed_resp.blocks = COUNT_W'(directed_rows[i].exp_blocks);
          send_request(directed_rows[i].action, directed_rows[i].size, faddr,
                       directed_rows[i].typed, typed_resp);
        end
      end
      for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
        quiet_phase = (phase == 1 && n >= 100 && n < 300);
        // Let the allocator run dry once before continuing.
        if (phase == 2 && n == 200) begin
          in_valid <= 1'b0;
          while (pending_responses.size() != 0) @(posedge clk);
          @(negedge clk);
        end
        random_item();
      end
      quiet_phase = 0;
      drain_and_settle();
    end

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= !quiet_phase && ($urandom_range(99) < 24);
  end

  initial out_stall = 1'b0;

  always @(posedge clk) begin
    response_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_responses.size() == 0) begin
        $display("%0t: unexpected response addr=%h status=%0d", $realtime,
                 out_result_address, out_status);
        error_count++;
      end else begin
        want = pending_responses.pop_front();
        if (out_result_address !== want.address || out_status !== want.status ||
            out_merged_count !== want.merged || out_block_count !== want.blocks) begin
          $display("%0t: mismatch expected addr=%h status=%0d merged=%0d blocks=%0d",
                   $realtime, want.address, want.status, want.merged, want.blocks);
          $display("%0t:          actual   addr=%h status=%0d merged=%0d blocks=%0d",
                   $realtime, out_result_address, out_status, out_merged_count,
                   out_block_count);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either channel.
  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ----- filelist.f -----
sv/ffha_pkg.sv
sv/ffha_mem.sv
sv/first_fit_heap_allocator.sv
verif/tb_first_fit_heap_allocator.sv
